// ----- rtl/core/sih_pkg.sv -----
// package for the string id hash block
// constants for the key limit, start values, salt, masks and tail words
// no dependencies
`timescale 1ns / 1ps

package sih_pkg;

  localparam int MAX_WORDS = 64;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);

  localparam logic [31:0] TAIL_FIRST  = 32'h9BE7_4448;
  localparam logic [31:0] TAIL_SECOND = 32'h66F4_2C48;
  localparam logic [31:0] ROTOR_INIT  = 32'hF4FA_8928;
  localparam logic [31:0] LANE_X_INIT = 32'h37A8_470E;
  localparam logic [31:0] LANE_Y_INIT = 32'h7758_B42B;
  localparam logic [31:0] SALT        = 32'h267B_0B11;
  localparam logic [31:0] X_OR_MASK   = 32'h0204_0801;
  localparam logic [31:0] X_AND_MASK  = 32'hBFEF_7FDF;
  localparam logic [31:0] Y_OR_MASK   = 32'h0080_4021;
  localparam logic [31:0] Y_AND_MASK  = 32'h7DFE_FBFF;

  // control from the key sequencer to the round unit
  typedef struct packed {
    logic        start;
    logic        clear;
    logic [31:0] word;
  } mix_ctrl_t;

  // status from the round unit back to the sequencer
  typedef struct packed {
    logic idle;
    logic done;
  } mix_stat_t;

endpackage

// ----- rtl/core/string_id_hash.sv -----
// string id hash top level: key word sequencer, result register, assertions
// depends on sih_pkg and sih_mix
//
// usage:
//   the host sends a key as 32-bit little-endian words on the input channel
//   (string_word, carries_word, last with in_valid / in_ready). carries_word
//   marks a real key word; last closes the key. a transaction with
//   carries_word = 0 and last = 1 hashes an empty key.
//   each closed key gives one transaction on the output channel
//   (hash_value, truncated with out_valid / out_ready).
// flow:
//   each key word is accepted and then runs one round in the round unit; the
//   input is not ready again until that round is done. the last transaction
//   adds two tail rounds and then loads the result into the output register.
//   a word past the 64-word limit, or a transaction without a word, runs no
//   word round. a round steps through phases because of the shared multiplier
//   in sih_mix: each round uses it twice and then folds the second product.
// reset:
//   rst clears the lanes, counters and output valid; the block is ready on
//   the first cycle after reset.
// stall:
//   the result register holds one finished hash; a new key is accepted and
//   hashed while it waits, and the block stalls only at the end of that key.
`timescale 1ns / 1ps

module string_id_hash
  import sih_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] string_word,
  input  logic        carries_word,
  input  logic        last,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] hash_value,
  output logic        truncated,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WORD  = 3'd1;
  localparam logic [2:0] S_TAIL1 = 3'd2;
  localparam logic [2:0] S_TAIL2 = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state;
  logic             launched;
  logic             key_last;
  logic [31:0]      word;
  logic [CNT_W-1:0] words_taken;
  logic             overflowed;

  mix_ctrl_t   ctrl;
  mix_stat_t   stat;
  logic [31:0] mix_hash;
  logic        in_fire;
  logic        take_word;
  logic        round_state;
  logic        out_load;

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign take_word   = carries_word && (words_taken < CNT_W'(MAX_WORDS));
  assign round_state = (state == S_WORD) || (state == S_TAIL1) || (state == S_TAIL2);
  assign out_load    = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    ctrl.start = round_state && !launched;
    ctrl.clear = out_load;
    unique case (state)
      S_TAIL1: ctrl.word = TAIL_FIRST;
      S_TAIL2: ctrl.word = TAIL_SECOND;
      default: ctrl.word = word;
    endcase
  end

  sih_mix u_mix (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat),
    .hash (mix_hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      launched    <= 1'b0;
      key_last    <= 1'b0;
      words_taken <= '0;
      overflowed  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.start) begin
        launched <= 1'b1;
      end else if (stat.done) begin
        launched <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            key_last <= last;
            if (carries_word && !take_word) begin
              overflowed <= 1'b1;
            end
            if (take_word) begin
              words_taken <= words_taken + CNT_W'(1);
              state       <= S_WORD;
            end else if (last) begin
              state <= S_TAIL1;
            end
          end
        end
        S_WORD: begin
          if (stat.done) begin
            state <= key_last ? S_TAIL1 : S_IDLE;
          end
        end
        S_TAIL1: begin
          if (stat.done) begin
            state <= S_TAIL2;
          end
        end
        S_TAIL2: begin
          if (stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            words_taken <= '0;
            overflowed  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word <= string_word;
    end
    if (out_load) begin
      hash_value <= mix_hash;
      truncated  <= overflowed;
    end
  end

  // word counter never passes the key limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    words_taken <= CNT_W'(MAX_WORDS))
    else $error("word counter beyond limit");

  // the round unit is idle whenever a new transaction can be accepted
  a_idle_on_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (stat.idle && !launched))
    else $error("round unit busy while ready");

  // a round is only started on an idle round unit
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> stat.idle)
    else $error("round started while busy");

  // loading a result presents it next cycle and frees the input side
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && in_ready && words_taken == '0))
    else $error("result load did not complete");

endmodule

// ----- rtl/core/sih_mix.sv -----
// round unit: two hash lanes, rotor and one shared 32x32 multiplier
// a round steps through the idle, y multiply and y fold phases; depends on sih_pkg
`timescale 1ns / 1ps

module sih_mix
  import sih_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mix_ctrl_t   ctrl,
  output mix_stat_t   stat,
  output logic [31:0] hash
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MUL_Y  = 2'd1;
  localparam logic [1:0] PH_FOLD_Y = 2'd2;

  logic [1:0]  phase;
  logic [31:0] lane_x;
  logic [31:0] lane_y;
  logic [31:0] rotor;
  logic [31:0] mul_y_op;
  logic [63:0] prod;

  logic [31:0] rotor_next;
  logic [31:0] round_key;
  logic [31:0] lx_w;
  logic [31:0] ly_w;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_out;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [32:0] sum_x;
  logic [31:0] lane_x_next;
  logic [32:0] sum_y;
  logic [31:0] lane_y_next;

  always_comb begin
    rotor_next = {rotor[30:0], rotor[31]};
    round_key  = SALT ^ rotor_next;
    lx_w       = lane_x ^ ctrl.word;
    ly_w       = lane_y ^ ctrl.word;
    op_x       = ((round_key + ly_w) | X_OR_MASK) & X_AND_MASK;
    op_y       = ((round_key + lx_w) | Y_OR_MASK) & Y_AND_MASK;
  end

  // shared multiplier: x lane at round start, y lane in the cycle after
  always_comb begin
    if (phase == PH_IDLE) begin
      op_a = lx_w;
      op_b = op_x;
    end else begin
      op_a = lane_y;
      op_b = mul_y_op;
    end
    mul_out = {32'd0, op_a} * {32'd0, op_b};
  end

  always_comb begin
    lo          = prod[31:0];
    hi          = prod[63:32];
    // x fold: low + high + (high nonzero), then end-around carry
    sum_x       = {1'b0, lo} + {1'b0, hi} + {32'd0, (hi != 32'd0)};
    lane_x_next = sum_x[31:0] + {31'd0, sum_x[32]};
    // y fold: low + 2*high + top bit of high, plus two on carry out
    sum_y       = {1'b0, lo} + {1'b0, hi[30:0], 1'b0} + {32'd0, hi[31]};
    lane_y_next = sum_y[31:0] + {30'd0, sum_y[32], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      lane_x <= LANE_X_INIT;
      lane_y <= LANE_Y_INIT;
      rotor  <= ROTOR_INIT;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (ctrl.clear) begin
            lane_x <= LANE_X_INIT;
            lane_y <= LANE_Y_INIT;
            rotor  <= ROTOR_INIT;
          end else if (ctrl.start) begin
            lane_y <= ly_w;
            rotor  <= rotor_next;
            phase  <= PH_MUL_Y;
          end
        end
        PH_MUL_Y: begin
          lane_x <= lane_x_next;
          phase  <= PH_FOLD_Y;
        end
        PH_FOLD_Y: begin
          lane_y <= lane_y_next;
          phase  <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((phase == PH_IDLE && ctrl.start && !ctrl.clear) || phase == PH_MUL_Y) begin
      prod <= mul_out;
    end
    if (phase == PH_IDLE) begin
      mul_y_op <= op_y;
    end
  end

  assign stat.idle = (phase == PH_IDLE);
  assign stat.done = (phase == PH_FOLD_Y);
  assign hash      = lane_x ^ lane_y;

endmodule

// ----- test/string_id_hash_test.sv -----
// testbench for string_id_hash: keys are sent as word transactions, hashes checked in order
// holds its own model of the lanes and rotor; depends on sih_pkg and string_id_hash
`timescale 1ns / 1ps

module string_id_hash_test;
  import sih_pkg::*;

  typedef struct packed {
    logic [31:0] hash;
    logic        trunc;
  } key_id_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] string_word = '0;
  logic        carries_word = 1'b0;
  logic        last = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] hash_value;
  logic        truncated;
  logic        out_valid;
  logic        out_ready = 1'b0;

  // predicted hashing state
  logic [31:0] lane_x;
  logic [31:0] lane_y;
  logic [31:0] rotor;
  logic [6:0]  word_count;
  logic        overflow_seen;

  key_id_t pending_ids[$];
  int      fail_count = 0;
  int      items_sent = 0;
  bit      steady = 1'b0;

  string_id_hash i_dut (
    .clk          (clk),
    .rst          (rst),
    .string_word  (string_word),
    .carries_word (carries_word),
    .last         (last),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .hash_value   (hash_value),
    .truncated    (truncated),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void restart_key();
    lane_x        = LANE_X_INIT;
    lane_y        = LANE_Y_INIT;
    rotor         = ROTOR_INIT;
    word_count    = '0;
    overflow_seen = 1'b0;
  endfunction

  function void mix_round(input logic [31:0] w);
    logic [31:0] key;
    logic [31:0] mx;
    logic [31:0] fx;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] prod;
    logic [63:0] t;
    rotor  = {rotor[30:0], rotor[31]};
    key    = SALT ^ rotor;
    lane_x = lane_x ^ w;
    lane_y = lane_y ^ w;
    mx     = ((key + lane_x) | Y_OR_MASK) & Y_AND_MASK;
    fx     = ((key + lane_y) | X_OR_MASK) & X_AND_MASK;
    // lane x: fold high half and its nonzero flag, then the carry
    prod   = {32'd0, lane_x} * {32'd0, fx};
    lo     = prod[31:0];
    hi     = prod[63:32];
    t      = {32'd0, lo} + {32'd0, hi} + {63'd0, (hi != 32'd0)};
    lane_x = t[31:0] + t[63:32];
    // lane y: low + 2*high + top bit of high, plus 2 on carry out
    prod   = {32'd0, lane_y} * {32'd0, mx};
    lo     = prod[31:0];
    hi     = prod[63:32];
    t      = {32'd0, lo} + {32'd0, hi[30:0], 1'b0} + {63'd0, hi[31]};
    lane_y = t[31:0];
    if (t[63:32] != 32'd0) begin
      lane_y = lane_y + 32'd2;
    end
  endfunction

  function void key_accept(input logic [31:0] w, input logic cw, input logic lst);
    key_id_t id;
    if (cw) begin
      if (word_count < MAX_WORDS) begin
        mix_round(w);
        word_count = word_count + 7'd1;
      end else begin
        overflow_seen = 1'b1;
      end
    end
    if (lst) begin
      mix_round(TAIL_FIRST);
      mix_round(TAIL_SECOND);
      id.hash  = lane_x ^ lane_y;
      id.trunc = overflow_seen;
      pending_ids = {pending_ids, id};
      restart_key();
    end
  endfunction

  function logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return {8'($urandom_range(32, 126)), 8'($urandom_range(32, 126)),
                       8'($urandom_range(32, 126)), 8'($urandom_range(32, 126))};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [31:0] w, input logic cw, input logic lst);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    string_word  <= w;
    carries_word <= cw;
    last         <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    key_accept(w, cw, lst);
    if (cw || lst) begin
      items_sent++;
    end
  endtask

  // word_close: last rides on the final word, otherwise a wordless transaction ends the key
  task automatic send_key(input int n, input bit word_close);
    int i;
    if (n == 0) begin
      send_item($urandom, 1'b0, 1'b1);
      return;
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item($urandom, 1'b0, 1'b0);
      end
      send_item(random_word(), 1'b1, word_close && (i == n - 1));
    end
    if (!word_close) begin
      send_item($urandom, 1'b0, 1'b1);
    end
  endtask

  task automatic test_directed();
    // empty keys, payload must not matter
    send_item(32'h0000_0000, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
    // step without a word, then single-word keys at the extremes and a short text word
    send_item(32'h1234_5678, 1'b0, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(32'h8000_0000, 1'b1, 1'b1);
    send_item(32'h0000_0001, 1'b1, 1'b1);
    send_item(32'h0063_6261, 1'b1, 1'b1);
    // zero word in the middle of a key is hashed
    send_item(32'h6C6C_6568, 1'b1, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0000_006F, 1'b1, 1'b1);
    // key closed by a transaction without a word
    send_item(32'hDEAD_BEEF, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(32'h0000_0000, 1'b0, 1'b1);
  endtask

  task automatic test_key_length_limit();
    send_key(MAX_WORDS - 1, 1'b1);
    send_key(MAX_WORDS, 1'b1);
    send_key(MAX_WORDS, 1'b0);
    send_key(MAX_WORDS + 1, 1'b1);
    send_key(MAX_WORDS + 16, 1'b0);
  endtask

  task automatic test_random_keys();
    int n;
    while (items_sent < 980) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(MAX_WORDS - 4, MAX_WORDS + 6);
        1: n = 0;
        default: n = $urandom_range(1, 8);
      endcase
      send_key(n, $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (10) send_key($urandom_range(0, 6), 1'b1);
  endtask

  // receiver: ready in random stretches with stalls of random length; always ready in the steady stream
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    key_id_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ids.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual hash_value %h truncated %b",
                 $time, hash_value, truncated);
        fail_count++;
      end else begin
        want = pending_ids.pop_front();
        if (hash_value !== want.hash) begin
          $display("%0t: hash_value expected %h actual %h", $time, want.hash, hash_value);
          fail_count++;
        end
        if (truncated !== want.trunc) begin
          $display("%0t: truncated expected %b actual %b", $time, want.trunc, truncated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    restart_key();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_key_length_limit();
    test_random_keys();
    test_steady_stream();
    in_valid <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
